@@ sv/pfb_pkg.sv @@
// Shared types and constants for the policy FIFO buffer.
package pfb_pkg;

    localparam int DATA_W     = 32;
    localparam int CNT_W      = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int DEPTH_DEF  = 16;
    localparam int CAP_RESET  = 16;

    localparam logic [1:0] MODE_FIXED   = 2'd0;
    localparam logic [1:0] MODE_DROP    = 2'd1;
    localparam logic [1:0] MODE_SLIDE   = 2'd2;
    localparam logic [1:0] MODE_PROMISE = 2'd3;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP  = 1'd1;

    typedef struct packed {
        logic              operation;
        logic [DATA_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic              dropped_oldest;
        logic              value_valid;
        logic [DATA_W-1:0] value_out;
        logic [CNT_W-1:0]  count_now;
        logic              full_now;
    } t_out_item;

    // Flags of one access, produced by the control logic.
    typedef struct packed {
        logic             accepted;
        logic             dropped_oldest;
        logic             value_valid;
        logic [CNT_W-1:0] count_now;
        logic             full_now;
    } t_stat;

    // Commands from the control logic to the entry store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_promise;
    } t_store_cmd;

endpackage

@@ sv/policy_fifo_buffer.sv @@
// Policy FIFO buffer: ring FIFO with fixed, dropping, sliding and promise policies.
// Channels: the input channel (i_in_valid/o_in_ready, i_in_item) carries one access
// per beat, an add of a value or a remove. Each accepted beat yields exactly one
// result beat on the output channel (o_out_valid/i_out_ready, o_out_item) with the
// accept and eviction flags, any removed value, the count and the full flag.
// Configuration beats (i_cfg_valid/o_cfg_ready) write the mode (index 0) or the
// capacity in use (index 1); every write empties the buffer. The configuration
// channel is always ready and is meant to be used while no access is in flight.
// The result is registered and appears in the cycle after the input beat is accepted.
// Throughput: one access per cycle when not stalled; the pointer and count update and
// the single registered read of the entry memory all complete in the accepting cycle.
// Stalls: the result register holds its beat while i_out_ready is low, and a new
// input beat is taken only in a cycle in which that beat leaves or the register is
// empty. Reset (synchronous, active low) empties the buffer, selects fixed mode and
// sets the capacity to CAP_RESET or the depth if smaller; no clearing pass is needed.
module policy_fifo_buffer #(
    parameter int DEPTH = pfb_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pfb_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pfb_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                       fire;
    logic                       cfg_we;
    pfb_pkg::t_stat             stat;
    pfb_pkg::t_store_cmd        cmd;
    logic [PW-1:0]              wr_addr;
    logic [PW-1:0]              rd_addr;
    logic [pfb_pkg::DATA_W-1:0] promise_data;
    logic [pfb_pkg::DATA_W-1:0] rd_data;

    logic           r_out_valid;
    pfb_pkg::t_stat r_stat;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign fire        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    pfb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_item         (i_in_item),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_stat         (stat),
        .o_cmd          (cmd),
        .o_wr_addr      (wr_addr),
        .o_rd_addr      (rd_addr),
        .o_promise_data (promise_data)
    );

    pfb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_wr_addr      (wr_addr),
        .i_wr_data      (i_in_item.item_value),
        .i_rd_addr      (rd_addr),
        .i_promise_data (promise_data),
        .o_rd_data      (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_stat <= stat;
        end
    end

    always_comb begin
        o_out_item.accepted       = r_stat.accepted;
        o_out_item.dropped_oldest = r_stat.dropped_oldest;
        o_out_item.value_valid    = r_stat.value_valid;
        o_out_item.value_out      = r_stat.value_valid ? rd_data : '0;
        o_out_item.count_now      = r_stat.count_now;
        o_out_item.full_now       = r_stat.full_now;
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/pfb_store.sv @@
// Entry store: ring memory with one write port and a registered read port.
module pfb_store #(
    parameter int DEPTH = pfb_pkg::DEPTH_DEF
) (
    input  logic                                        i_clk,
    input  pfb_pkg::t_store_cmd                         i_cmd,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [pfb_pkg::DATA_W-1:0]                  i_wr_data,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_rd_addr,
    input  logic [pfb_pkg::DATA_W-1:0]                  i_promise_data,
    output logic [pfb_pkg::DATA_W-1:0]                  o_rd_data
);

    logic [pfb_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [pfb_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // In promise mode the held value takes the place of the ring read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            if (i_cmd.rd_promise) begin
                r_rd_data <= i_promise_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/pfb_ctrl.sv @@
// Control: configuration registers, ring pointers, count and promise state.
module pfb_ctrl #(
    parameter int DEPTH = pfb_pkg::DEPTH_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_fire,
    input  pfb_pkg::t_in_item                           i_item,
    input  logic                                        i_cfg_we,
    input  logic [pfb_pkg::CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [pfb_pkg::CFG_DATA_W-1:0]              i_cfg_data,
    output pfb_pkg::t_stat                              o_stat,
    output pfb_pkg::t_store_cmd                         o_cmd,
    output logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] o_wr_addr,
    output logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] o_rd_addr,
    output logic [pfb_pkg::DATA_W-1:0]                  o_promise_data
);

    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = pfb_pkg::CNT_W;
    localparam int CMP_W = (PW + 1 > CW) ? PW + 1 : CW;
    localparam logic [CW-1:0] CAP_INIT =
        CW'((pfb_pkg::CAP_RESET > DEPTH) ? DEPTH : pfb_pkg::CAP_RESET);

    logic [1:0]                 r_mode;
    logic [CW-1:0]              r_cap;
    logic [PW-1:0]              r_head;
    logic [PW-1:0]              r_tail;
    logic [CW-1:0]              r_count;
    logic                       r_done;
    logic [pfb_pkg::DATA_W-1:0] r_pval;

    logic [CW-1:0] n_count;
    logic [PW-1:0] n_head;
    logic [PW-1:0] n_tail;
    logic          n_done;
    logic [CW-1:0] cap_wr;
    logic          is_promise;
    logic          is_add;
    logic          is_full;
    logic          slide;
    logic          store_ok;
    logic          rem_ok;
    logic          head_adv;
    logic          p_set;
    logic          p_read;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] idx,
                                                input logic [CW-1:0] cap);
        logic [CMP_W-1:0] inc;
        inc = CMP_W'(idx) + CMP_W'(1);
        return (inc >= CMP_W'(cap)) ? '0 : inc[PW-1:0];
    endfunction

    always_comb begin
        cap_wr = i_cfg_data[CW-1:0];
        if (cap_wr == '0) begin
            cap_wr = CW'(1);
        end else if (32'(cap_wr) > DEPTH) begin
            cap_wr = CW'(DEPTH);
        end
    end

    assign is_promise = (r_mode == pfb_pkg::MODE_PROMISE);
    assign is_add     = (i_item.operation == pfb_pkg::OP_ADD);
    assign is_full    = (r_count >= r_cap);
    assign slide      = is_add && !is_promise && is_full && (r_mode == pfb_pkg::MODE_SLIDE);
    assign store_ok   = is_add && !is_promise && (!is_full || slide);
    assign rem_ok     = !is_add && !is_promise && (r_count != '0);
    assign head_adv   = slide || rem_ok;
    assign p_set      = is_add && is_promise && !r_done;
    assign p_read     = !is_add && is_promise && r_done;

    assign n_head  = head_adv ? ring_next(r_head, r_cap) : r_head;
    assign n_tail  = store_ok ? ring_next(r_tail, r_cap) : r_tail;
    assign n_count = r_count + CW'(store_ok) - CW'(head_adv);
    assign n_done  = r_done || p_set;

    always_comb begin
        o_stat.accepted       = store_ok || p_set;
        o_stat.dropped_oldest = slide;
        o_stat.value_valid    = rem_ok || p_read;
        if (is_promise) begin
            o_stat.count_now = CW'(n_done);
            o_stat.full_now  = n_done;
        end else begin
            o_stat.count_now = n_count;
            o_stat.full_now  = (r_mode == pfb_pkg::MODE_FIXED) && (n_count >= r_cap);
        end
    end

    assign o_cmd.wr_en      = i_fire && store_ok;
    assign o_cmd.rd_en      = i_fire && (rem_ok || p_read);
    assign o_cmd.rd_promise = is_promise;
    assign o_wr_addr        = r_tail;
    assign o_rd_addr        = r_head;
    assign o_promise_data   = r_pval;

    // Any register write starts a fresh, empty buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pfb_pkg::MODE_FIXED;
            r_cap   <= CAP_INIT;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_pval  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == pfb_pkg::REG_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end else begin
                r_cap <= cap_wr;
            end
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_pval  <= '0;
        end else if (i_fire) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= n_done;
            if (p_set) begin
                r_pval <= i_item.item_value;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("ring count exceeds capacity in use");

    a_drop_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_stat.dropped_oldest) |-> (o_stat.accepted && r_count == r_cap))
        else $error("eviction without a full ring or without storing");

    a_remove_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_cfg_we && rem_ok) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not lower the count by one");

    a_promise_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_promise && r_done && !i_cfg_we) |=> (r_done && $stable(r_pval)))
        else $error("promise value changed after delivery");
`endif

endmodule

@@ dv/pfb_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the policy FIFO buffer: predicts every access and compares result beats.
module pfb_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  pfb_pkg::t_in_item              i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  pfb_pkg::t_out_item             i_out_item,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_mismatches
);

    // Own copy of the buffer state and its two registers.
    logic [pfb_pkg::DATA_W-1:0] ring_words [pfb_pkg::DEPTH_DEF];
    logic [pfb_pkg::CNT_W-1:0]  rd_ptr;
    logic [pfb_pkg::CNT_W-1:0]  wr_ptr;
    logic [pfb_pkg::CNT_W-1:0]  fill_level;
    logic                       promise_held;
    logic [pfb_pkg::DATA_W-1:0] promise_word;
    logic [1:0]                 buf_mode;
    logic [pfb_pkg::CNT_W-1:0]  cap_in_use;

    pfb_pkg::t_out_item replies_due [$];

    task automatic empty_buffer();
        rd_ptr       = '0;
        wr_ptr       = '0;
        fill_level   = '0;
        promise_held = 1'b0;
        promise_word = '0;
    endtask

    function automatic logic [pfb_pkg::CNT_W-1:0] ring_advance(
        logic [pfb_pkg::CNT_W-1:0] ptr);
        return (ptr + 1'b1 >= cap_in_use) ? '0 : ptr + 1'b1;
    endfunction

    // Any register write also empties the buffer, even if the value is unchanged.
    task automatic write_register(logic [pfb_pkg::CFG_IDX_W-1:0] idx,
                                  logic [pfb_pkg::CFG_DATA_W-1:0] data);
        logic [pfb_pkg::CNT_W-1:0] cap;
        case (idx)
            pfb_pkg::REG_MODE: begin
                buf_mode = data[1:0];
                empty_buffer();
            end
            pfb_pkg::REG_CAP: begin
                cap = data;
                if (cap == 0)
                    cap = pfb_pkg::CNT_W'(1);
                if (cap > pfb_pkg::DEPTH_DEF)
                    cap = pfb_pkg::CNT_W'(pfb_pkg::DEPTH_DEF);
                cap_in_use = cap;
                empty_buffer();
            end
            default: ;
        endcase
    endtask

    function automatic pfb_pkg::t_out_item buffer_access(pfb_pkg::t_in_item beat);
        pfb_pkg::t_out_item res;
        logic               is_full;
        res = '0;
        if (buf_mode == pfb_pkg::MODE_PROMISE) begin
            if (beat.operation == pfb_pkg::OP_ADD) begin
                if (!promise_held) begin
                    promise_word = beat.item_value;
                    promise_held = 1'b1;
                    res.accepted = 1'b1;
                end
            end else if (promise_held) begin
                res.value_valid = 1'b1;
                res.value_out   = promise_word;
            end
            res.count_now = pfb_pkg::CNT_W'(promise_held);
            res.full_now  = promise_held;
        end else begin
            if (beat.operation == pfb_pkg::OP_ADD) begin
                is_full = (fill_level >= cap_in_use);
                // Sliding mode makes room by evicting the oldest entry first.
                if (is_full && buf_mode == pfb_pkg::MODE_SLIDE) begin
                    rd_ptr             = ring_advance(rd_ptr);
                    fill_level         = fill_level - 1'b1;
                    res.dropped_oldest = 1'b1;
                    is_full            = 1'b0;
                end
                if (!is_full) begin
                    ring_words[wr_ptr[3:0]] = beat.item_value;
                    wr_ptr                  = ring_advance(wr_ptr);
                    fill_level              = fill_level + 1'b1;
                    res.accepted            = 1'b1;
                end
            end else if (fill_level != 0) begin
                res.value_valid = 1'b1;
                res.value_out   = ring_words[rd_ptr[3:0]];
                rd_ptr          = ring_advance(rd_ptr);
                fill_level      = fill_level - 1'b1;
            end
            res.count_now = fill_level;
            res.full_now  = (buf_mode == pfb_pkg::MODE_FIXED) && (fill_level >= cap_in_use);
        end
        return res;
    endfunction

    task automatic check_field(string field, logic [pfb_pkg::DATA_W-1:0] want,
                               logic [pfb_pkg::DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        pfb_pkg::t_out_item want;
        if (!i_rst_n) begin
            buf_mode   = pfb_pkg::MODE_FIXED;
            cap_in_use = pfb_pkg::CNT_W'(pfb_pkg::CAP_RESET);
            empty_buffer();
            replies_due.delete();
        end else begin
            // The result beat belongs to an earlier access, so compare before predicting.
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result beat with no access outstanding, actual %p",
                             $time, i_out_item);
                    o_mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("accepted", pfb_pkg::DATA_W'(want.accepted),
                                pfb_pkg::DATA_W'(i_out_item.accepted));
                    check_field("dropped_oldest", pfb_pkg::DATA_W'(want.dropped_oldest),
                                pfb_pkg::DATA_W'(i_out_item.dropped_oldest));
                    check_field("value_valid", pfb_pkg::DATA_W'(want.value_valid),
                                pfb_pkg::DATA_W'(i_out_item.value_valid));
                    check_field("value_out", want.value_out, i_out_item.value_out);
                    check_field("count_now", pfb_pkg::DATA_W'(want.count_now),
                                pfb_pkg::DATA_W'(i_out_item.count_now));
                    check_field("full_now", pfb_pkg::DATA_W'(want.full_now),
                                pfb_pkg::DATA_W'(i_out_item.full_now));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready)
                replies_due.push_back(buffer_access(i_in_item));
        end
        o_pending = replies_due.size();
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Stimulus and verdict for the policy FIFO buffer, with the result checker beside it.
module testbench;

    localparam int HOLD_CYCLES = 60;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 46;

    logic clk = 1'b0;
    logic rst_n;

    logic                           in_valid;
    logic                           in_ready;
    pfb_pkg::t_in_item              in_item;
    logic                           out_valid;
    logic                           out_ready;
    pfb_pkg::t_out_item             out_item;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [pfb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pfb_pkg::CFG_DATA_W-1:0] cfg_data;

    int   replies_outstanding;
    int   mismatch_total;
    int   idle_pct;
    logic hold_request;
    logic hold_done;

    always #1 clk = ~clk;

    policy_fifo_buffer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pfb_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (replies_outstanding),
        .o_mismatches (mismatch_total)
    );

    initial begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request && !hold_done) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                out_ready = ($urandom_range(99) >= idle_pct);
            end
        end
    end

    function automatic logic [pfb_pkg::DATA_W-1:0] random_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly in-range capacities, with the clamped values 0 and 17 to 31 now and then.
    function automatic logic [pfb_pkg::CFG_DATA_W-1:0] pick_capacity();
        case ($urandom_range(9))
            0:       return pfb_pkg::CFG_DATA_W'(1);
            1:       return pfb_pkg::CFG_DATA_W'(pfb_pkg::DEPTH_DEF);
            2:       return $urandom_range(1) ? '0 :
                         pfb_pkg::CFG_DATA_W'($urandom_range(31, pfb_pkg::DEPTH_DEF + 1));
            default: return pfb_pkg::CFG_DATA_W'($urandom_range(pfb_pkg::DEPTH_DEF, 1));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_access(logic op, logic [pfb_pkg::DATA_W-1:0] value);
        pfb_pkg::t_in_item beat;
        beat.operation  = op;
        beat.item_value = value;
        while ($urandom_range(99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Registers are only written once every access has produced its result.
    task automatic write_config(logic [pfb_pkg::CFG_IDX_W-1:0] idx,
                                logic [pfb_pkg::CFG_DATA_W-1:0] data);
        in_valid = 1'b0;
        while (replies_outstanding != 0) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int add_pct;
        int order;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = pfb_pkg::REG_MODE;
        cfg_data     = '0;
        hold_request = 1'b0;
        idle_pct     = 20;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fixed mode at reset capacity: remove from empty, extreme values.
        send_access(pfb_pkg::OP_REMOVE, '1);
        send_access(pfb_pkg::OP_ADD, '0);
        send_access(pfb_pkg::OP_ADD, '1);
        send_access(pfb_pkg::OP_REMOVE, 32'h5A5A_A5A5);
        send_access(pfb_pkg::OP_REMOVE, '0);
        send_access(pfb_pkg::OP_REMOVE, '0);
        // A capacity of zero is taken as one, so the second add is refused.
        write_config(pfb_pkg::REG_CAP, '0);
        send_access(pfb_pkg::OP_ADD, 32'h1234_5678);
        send_access(pfb_pkg::OP_ADD, 32'h8765_4321);
        send_access(pfb_pkg::OP_REMOVE, '0);
        // Dropping mode discards the newest beat when full.
        write_config(pfb_pkg::REG_CAP, pfb_pkg::CFG_DATA_W'(2));
        write_config(pfb_pkg::REG_MODE, pfb_pkg::CFG_DATA_W'(pfb_pkg::MODE_DROP));
        send_access(pfb_pkg::OP_ADD, 32'h0000_0001);
        send_access(pfb_pkg::OP_ADD, 32'h0000_0002);
        send_access(pfb_pkg::OP_ADD, 32'h0000_0003);
        send_access(pfb_pkg::OP_REMOVE, '0);
        // Sliding mode evicts the oldest entry instead.
        write_config(pfb_pkg::REG_MODE, pfb_pkg::CFG_DATA_W'(pfb_pkg::MODE_SLIDE));
        send_access(pfb_pkg::OP_ADD, 32'hAAAA_0001);
        send_access(pfb_pkg::OP_ADD, 32'hAAAA_0002);
        send_access(pfb_pkg::OP_ADD, 32'hAAAA_0003);
        send_access(pfb_pkg::OP_REMOVE, '0);
        send_access(pfb_pkg::OP_REMOVE, '0);
        // Promise mode keeps the first value and never consumes it.
        write_config(pfb_pkg::REG_MODE, pfb_pkg::CFG_DATA_W'(pfb_pkg::MODE_PROMISE));
        send_access(pfb_pkg::OP_REMOVE, '0);
        send_access(pfb_pkg::OP_ADD, 32'hC0DE_0001);
        send_access(pfb_pkg::OP_ADD, 32'hC0DE_0002);
        send_access(pfb_pkg::OP_REMOVE, '0);
        send_access(pfb_pkg::OP_REMOVE, '1);
        write_config(pfb_pkg::REG_MODE, pfb_pkg::CFG_DATA_W'(pfb_pkg::MODE_FIXED));
        write_config(pfb_pkg::REG_CAP, pfb_pkg::CFG_DATA_W'(31));

        for (int phase = 0; phase < PHASES; phase++) begin
            order = $urandom_range(2);
            if (order != 1)
                write_config(pfb_pkg::REG_MODE, pfb_pkg::CFG_DATA_W'(phase % 4));
            if (order != 0)
                write_config(pfb_pkg::REG_CAP, pick_capacity());
            if (order == 2)
                write_config(pfb_pkg::REG_MODE, pfb_pkg::CFG_DATA_W'(phase % 4));
            // Each phase picks at random an add share that tends to fill, drain or balance the ring.
            case ($urandom_range(2))
                0:       add_pct = 75;
                1:       add_pct = 30;
                default: add_pct = 50;
            endcase
            idle_pct = (phase == 5) ? 0 : 20;
            if (phase == 8)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS)
                send_access(($urandom_range(99) < add_pct) ? pfb_pkg::OP_ADD : pfb_pkg::OP_REMOVE,
                            random_word());
        end

        in_valid = 1'b0;
        while (replies_outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_total == 0 && replies_outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ policy_fifo_buffer.f @@
sv/pfb_pkg.sv
sv/pfb_store.sv
sv/pfb_ctrl.sv
sv/policy_fifo_buffer.sv
dv/pfb_result_checker.sv
dv/testbench.sv
